### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### rtl/cpbe_pkg.sv
package cpbe_pkg;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    MODE_NONE   = 3'd0,
    MODE_BLEND  = 3'd1,
    MODE_ADD    = 3'd2,
    MODE_MOD    = 3'd3,
    MODE_KEEP   = 3'd4
  } blend_mode_t;

  typedef enum logic [2:0] {
    CFG_CLIP_MIN_X = 3'd0,
    CFG_CLIP_MIN_Y = 3'd1,
    CFG_CLIP_MAX_X = 3'd2,
    CFG_CLIP_MAX_Y = 3'd3,
    CFG_BLEND_MODE = 3'd4,
    CFG_DRAW_COLOR = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_MUL,
    ST_WB
  } state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        pixel_value;
    logic               batch_last;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        accepted;
    logic        batch_done;
  } out_beat_t;

  // Draw settings seen by the blend datapath
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] color;
  } blend_cfg_t;

  localparam logic [7:0] CHAN_MAX = 8'd255;

  // floor(p / 255) for any 16-bit product of two 8-bit values
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] t;
    t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
    return t[15:8];
  endfunction

endpackage

### rtl/clipped_point_blend_engine.sv
// Clipped point blend engine: keeps an ARGB8888 frame of FRAME_WIDTH x FRAME_HEIGHT
// pixels in one single-port synchronous memory (row-major, addr = y*FRAME_WIDTH + x)
// and handles one beat at a time: draw a point (clip test, read, blend by blend_mode
// with draw_color, write back), write a raw pixel, or read a pixel. Every input beat
// gives exactly one result beat. An item passes through four states from acceptance
// to its result register: address multiply, memory read, channel multiplies, then
// divide/sum and write-back. A new beat is not taken while an item is in flight: the
// next beat waits until the engine is idle again after write-back. Write-back
// also waits while the previous result is still held under out_stall. Since an item
// finishes its write-back before the next one reads, overlapping accesses to one
// pixel are never in flight. The result sits in an output register, so the next beat
// is taken while an earlier result still waits under out_stall.
// Pixels never written read back undefined. Configuration writes (cfg_ready is always
// high) must only happen while the engine is idle.
`include "assert_macros.svh"

module clipped_point_blend_engine
  import cpbe_pkg::*;
#(
  parameter int unsigned FRAME_WIDTH  = 256,
  parameter int unsigned FRAME_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // item input
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned Depth = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned XW    = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int unsigned YW    = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

  // ---------------- configuration registers ----------------
  logic [7:0]  clip_min_x_r, clip_min_y_r, clip_max_x_r, clip_max_y_r;
  logic [2:0]  blend_mode_r;
  logic [31:0] draw_color_r;
  logic        cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_min_x_r <= 8'd0;
      clip_min_y_r <= 8'd0;
      clip_max_x_r <= 8'd255;
      clip_max_y_r <= 8'd255;
      blend_mode_r <= MODE_NONE;
      draw_color_r <= 32'd0;
    end else if (cfg_wr) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CLIP_MIN_X: clip_min_x_r <= cfg_data[7:0];
        CFG_CLIP_MIN_Y: clip_min_y_r <= cfg_data[7:0];
        CFG_CLIP_MAX_X: clip_max_x_r <= cfg_data[7:0];
        CFG_CLIP_MAX_Y: clip_max_y_r <= cfg_data[7:0];
        CFG_BLEND_MODE: blend_mode_r <= cfg_data[2:0];
        CFG_DRAW_COLOR: draw_color_r <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---------------- sequencer state ----------------
  state_t      state_r, state_nxt;
  in_beat_t    item_r;
  logic [AddrW-1:0] addr_r, addr_nxt;
  logic        hit_r, hit_nxt;      // operation lands on the frame (a draw also inside the clip)
  out_beat_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        in_take;
  logic        out_free;            // result register can load this cycle
  logic        out_load;
  logic        mem_re, mem_we;
  logic        blend_en;
  logic [31:0] mem_wdata, mem_rdata;
  logic [31:0] blend_result;
  blend_cfg_t  blend_cfg;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // frame and clip tests on the held item
  logic [15:0] x_u, y_u;
  logic        in_frame, in_clip;
  logic [XW-1:0] x_idx;
  logic [YW-1:0] y_idx;

  assign x_u   = item_r.pos_x[15:0];
  assign y_u   = item_r.pos_y[15:0];
  assign x_idx = x_u[XW-1:0];
  assign y_idx = y_u[YW-1:0];

  assign in_frame = !x_u[15] && !y_u[15] &&
                    (x_u < 16'(FRAME_WIDTH)) && (y_u < 16'(FRAME_HEIGHT));
  // an empty rectangle (min above max) fails one of the two compares
  assign in_clip  = !x_u[15] && !y_u[15] &&
                    (x_u >= {8'd0, clip_min_x_r}) && (x_u <= {8'd0, clip_max_x_r}) &&
                    (y_u >= {8'd0, clip_min_y_r}) && (y_u <= {8'd0, clip_max_y_r});

  always_comb begin
    addr_nxt = addr_r;
    hit_nxt  = hit_r;
    if (state_r == ST_ADDR) begin
      addr_nxt = AddrW'(y_idx) * AddrW'(FRAME_WIDTH) + AddrW'(x_idx);
      case (opcode_t'(item_r.opcode))
        OP_DRAW:  hit_nxt = in_frame && in_clip;
        OP_WRITE: hit_nxt = in_frame;
        OP_READ:  hit_nxt = in_frame;
        default:  hit_nxt = 1'b0;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_WB;
      ST_WB:   if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    blend_en = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_READ: mem_re = hit_r;
      ST_MUL:  blend_en = 1'b1;
      ST_WB: begin
        out_load = out_free;
        mem_we   = out_free && hit_r &&
                   ((item_r.opcode == OP_DRAW) || (item_r.opcode == OP_WRITE));
      end
      default: ;
    endcase
  end

  assign mem_wdata = (item_r.opcode == OP_DRAW) ? blend_result : item_r.pixel_value;

  // result beat
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt       = 1'b1;
      out_nxt.accepted    = hit_r;
      out_nxt.batch_done  = item_r.batch_last;
      out_nxt.read_data   = 32'd0;
      if (hit_r) begin
        case (opcode_t'(item_r.opcode))
          OP_DRAW:  out_nxt.read_data = blend_result;
          OP_WRITE: out_nxt.read_data = item_r.pixel_value;
          OP_READ:  out_nxt.read_data = mem_rdata;
          default:  out_nxt.read_data = 32'd0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_data;
    end
    addr_r <= addr_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- datapath ----------------
  assign blend_cfg.mode  = blend_mode_r;
  assign blend_cfg.color = draw_color_r;

  cpbe_frame_mem #(
    .DEPTH  (Depth),
    .ADDR_W (AddrW)
  ) u_mem (
    .clk   (clk),
    .re    (mem_re),
    .we    (mem_we),
    .addr  (addr_r),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  cpbe_blend_unit u_blend (
    .clk     (clk),
    .en      (blend_en),
    .cfg     (blend_cfg),
    .old_pix (mem_rdata),
    .result  (blend_result)
  );

  // ---------------- checks ----------------
  `ASSERT_CLK(a_take_starts_addr, clk, rst_n, in_take |=> (state_r == ST_ADDR))
  `ASSERT_CLK(a_out_from_wb, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == ST_WB))
  `ASSERT_CLK(a_write_reports_hit, clk, rst_n, mem_we |=> (out_valid_r && out_r.accepted))
  `ASSERT_NEVER(a_reject_has_data, clk, rst_n,
                out_valid_r && !out_r.accepted && (out_r.read_data != 32'd0))

endmodule

### rtl/cpbe_frame_mem.sv
module cpbe_frame_mem #(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = 16
) (
  input  logic              clk,
  input  logic              re,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [31:0]       wdata,
  output logic [31:0]       rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/cpbe_blend_unit.sv
module cpbe_blend_unit
  import cpbe_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  blend_cfg_t  cfg,
  input  logic [31:0] old_pix,
  output logic [31:0] result
);

  // stage 1: registered products, one lane per channel (no source lane for alpha)
  logic [15:0] p_src_r [3];
  logic [15:0] p_dst_r [4];
  logic [15:0] p_src_nxt [3];
  logic [15:0] p_dst_nxt [4];
  logic [31:0] old_r;

  logic [7:0] src_a;
  logic [7:0] inv_a;

  assign src_a = cfg.color[31:24];
  assign inv_a = CHAN_MAX - src_a;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_src_nxt[i] = 16'(src_a) * 16'(cfg.color[8*i +: 8]);
      if (cfg.mode == MODE_MOD) begin
        p_dst_nxt[i] = 16'(cfg.color[8*i +: 8]) * 16'(old_pix[8*i +: 8]);
      end else begin
        p_dst_nxt[i] = 16'(inv_a) * 16'(old_pix[8*i +: 8]);
      end
    end
    p_dst_nxt[3] = 16'(inv_a) * 16'(old_pix[31:24]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_src_r <= p_src_nxt;
      p_dst_r <= p_dst_nxt;
      old_r   <= old_pix;
    end
  end

  // stage 2: divide by 255, sum and select per mode
  always_comb begin
    logic [7:0] s;
    logic [7:0] d;
    logic [8:0] sum;
    result = old_r;
    for (int i = 0; i < 3; i++) begin
      s   = div255(p_src_r[i]);
      d   = div255(p_dst_r[i]);
      sum = {1'b0, s} + {1'b0, old_r[8*i +: 8]};
      case (blend_mode_t'(cfg.mode))
        MODE_NONE:  result[8*i +: 8] = cfg.color[8*i +: 8];
        MODE_BLEND: result[8*i +: 8] = s + d;
        MODE_ADD:   result[8*i +: 8] = sum[8] ? CHAN_MAX : sum[7:0];
        MODE_MOD:   result[8*i +: 8] = d;
        default:    result[8*i +: 8] = old_r[8*i +: 8];
      endcase
    end
    case (blend_mode_t'(cfg.mode))
      MODE_NONE:  result[31:24] = src_a;
      MODE_BLEND: result[31:24] = src_a + div255(p_dst_r[3]);
      default:    result[31:24] = old_r[31:24];
    endcase
  end

endmodule

### verif/tb.sv
module tb;
  import cpbe_pkg::*;

  localparam int FRAME_W     = 256;
  localparam int FRAME_H     = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 110;

  // Clock and reset. Every block input starts at a known value.
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_beat_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  always #4 clk = ~clk;

  clipped_point_blend_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the engine's registers, at their reset values.
  logic [7:0]  clip_lo_x   = 8'd0;
  logic [7:0]  clip_lo_y   = 8'd0;
  logic [7:0]  clip_hi_x   = 8'd255;
  logic [7:0]  clip_hi_y   = 8'd255;
  logic [2:0]  mode_reg    = MODE_NONE;
  logic [31:0] paint_color = '0;

  // Shadow frame. frame_model is updated as beats are accepted;
  // touched is updated as beats are generated, so the generator never
  // lets a read or a landing draw hit a pixel that holds nothing yet.
  logic [31:0] frame_model [0:FRAME_W*FRAME_H-1];
  bit          touched     [0:FRAME_W*FRAME_H-1];

  in_beat_t  cmd_queue[$];        // beats waiting for the driver
  out_beat_t pending_outcomes[$]; // predicted results, oldest first

  int  issued       = 0;  // beats taken from cmd_queue by the driver
  int  received     = 0;  // result beats seen by the monitor
  int  err_count    = 0;
  int  draws_landed = 0;
  int  settings     = 0;
  int  cycle_count  = 0;
  bit  steady       = 1'b0; // no idling on either side while set

  // floor(p*q/255) on 8-bit channel values
  function automatic int unsigned scale8(input int unsigned p, input int unsigned q);
    return (p * q) / 255;
  endfunction

  // New pixel value for a draw that lands, from the stored one.
  function automatic logic [31:0] shade(input logic [31:0] old);
    int unsigned a, inv, sum;
    int          k;
    logic [31:0] res;
    a   = paint_color[31:24];
    inv = 255 - a;
    res = old;
    case (mode_reg)
      MODE_NONE: res = paint_color;
      MODE_BLEND: begin
        // premultiplied source-over; the sum never passes 255
        res[31:24] = 8'(a + scale8(inv, old[31:24]));
        for (k = 0; k < 3; k++)
          res[8*k +: 8] = 8'(scale8(a, paint_color[8*k +: 8]) + scale8(inv, old[8*k +: 8]));
      end
      MODE_ADD: begin
        for (k = 0; k < 3; k++) begin
          sum = scale8(a, paint_color[8*k +: 8]) + old[8*k +: 8];
          res[8*k +: 8] = (sum > 255) ? 8'd255 : 8'(sum);
        end
      end
      MODE_MOD: begin
        for (k = 0; k < 3; k++)
          res[8*k +: 8] = 8'(scale8(paint_color[8*k +: 8], old[8*k +: 8]));
      end
      default: res = old; // keep and the unused mode codes
    endcase
    return res;
  endfunction

  function automatic bit on_frame(input int x, input int y);
    return x >= 0 && y >= 0 && x < FRAME_W && y < FRAME_H;
  endfunction

  function automatic bit on_clip(input int x, input int y);
    return x >= int'(clip_lo_x) && x <= int'(clip_hi_x) &&
           y >= int'(clip_lo_y) && y <= int'(clip_hi_y);
  endfunction

  // Result of one accepted beat; updates the shadow frame.
  function automatic out_beat_t pixel_outcome(input in_beat_t b);
    out_beat_t   r;
    int          x, y;
    logic [15:0] addr;
    x    = $signed(b.pos_x);
    y    = $signed(b.pos_y);
    addr = {y[7:0], x[7:0]};
    r    = '0;
    r.batch_done = b.batch_last;
    case (b.opcode)
      OP_DRAW: begin
        if (on_frame(x, y) && on_clip(x, y)) begin
          frame_model[addr] = shade(frame_model[addr]);
          r.read_data = frame_model[addr];
          r.accepted  = 1'b1;
          draws_landed++;
        end
      end
      OP_WRITE: begin
        if (on_frame(x, y)) begin
          frame_model[addr] = b.pixel_value;
          r.read_data = b.pixel_value;
          r.accepted  = 1'b1;
        end
      end
      OP_READ: begin
        if (on_frame(x, y)) begin
          r.read_data = frame_model[addr];
          r.accepted  = 1'b1;
        end
      end
      default: ; // unused opcode: nothing happens
    endcase
    return r;
  endfunction

  // Driver: a beat moves at an edge with in_valid high and in_stall low.
  // Valid and payload only change once the current beat has moved.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        pending_outcomes.push_back(pixel_outcome(in_data));
      if (!in_valid || !in_stall) begin
        if (cmd_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
          in_data  <= cmd_queue.pop_front();
          in_valid <= 1'b1;
          issued++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction and
  // stalls the result channel at random.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        received++;
        if (pending_outcomes.size() == 0) begin
          $error("result beat with nothing predicted: read_data %h", out_data.read_data);
          err_count++;
        end else begin
          want = pending_outcomes.pop_front();
          if (out_data.read_data !== want.read_data) begin
            $error("read_data mismatch: expected %h, got %h", want.read_data,
                   out_data.read_data);
            err_count++;
          end
          if (out_data.accepted !== want.accepted) begin
            $error("accepted mismatch: expected %b, got %b", want.accepted,
                   out_data.accepted);
            err_count++;
          end
          if (out_data.batch_done !== want.batch_done) begin
            $error("batch_done mismatch: expected %b, got %b", want.batch_done,
                   out_data.batch_done);
            err_count++;
          end
        end
      end
      out_stall <= !steady && ($urandom_range(0, 99) < 15);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Wait until every queued beat went in and every result came out.
  task automatic drain();
    do @(posedge clk);
    while (cmd_queue.size() != 0 || issued != received || pending_outcomes.size() != 0);
  endtask

  // One register write; the shadow copy follows once the write is taken.
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CLIP_MIN_X: clip_lo_x   = value[7:0];
      CFG_CLIP_MIN_Y: clip_lo_y   = value[7:0];
      CFG_CLIP_MAX_X: clip_hi_x   = value[7:0];
      CFG_CLIP_MAX_Y: clip_hi_y   = value[7:0];
      CFG_BLEND_MODE: mode_reg    = value[2:0];
      CFG_DRAW_COLOR: paint_color = value;
      default: ;
    endcase
  endtask

  // Registers only change with the engine idle.
  task automatic apply_settings(input int lx, input int ly, input int hx, input int hy,
                                input logic [2:0] mode, input logic [31:0] color);
    drain();
    write_reg(CFG_CLIP_MIN_X, 32'(lx));
    write_reg(CFG_CLIP_MIN_Y, 32'(ly));
    write_reg(CFG_CLIP_MAX_X, 32'(hx));
    write_reg(CFG_CLIP_MAX_Y, 32'(hy));
    write_reg(CFG_BLEND_MODE, 32'(mode));
    write_reg(CFG_DRAW_COLOR, color);
    settings++;
  endtask

  // Queue one beat. A read or a landing draw on a pixel that holds nothing
  // yet gets a raw write of random content in front of it.
  task automatic push_item(input opcode_t op, input int x, input int y,
                           input logic [31:0] pix, input bit last);
    in_beat_t    b;
    logic [15:0] addr;
    bit          needs_data;
    addr       = {y[7:0], x[7:0]};
    needs_data = on_frame(x, y) && (op == OP_READ || (op == OP_DRAW && on_clip(x, y)));
    b.pos_x       = x[15:0];
    b.pos_y       = y[15:0];
    b.batch_last  = 1'b0;
    if (needs_data && !touched[addr]) begin
      b.opcode      = OP_WRITE;
      b.pixel_value = $urandom;
      cmd_queue.push_back(b);
      touched[addr] = 1'b1;
    end
    if (op == OP_WRITE && on_frame(x, y))
      touched[addr] = 1'b1;
    b.opcode      = op;
    b.pixel_value = pix;
    b.batch_last  = last;
    cmd_queue.push_back(b);
  endtask

  // Coordinate near the frame and clip borders, or at the far ends.
  function automatic int pick_edge(input int lo, input int hi);
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return lo - 1;
      4: return lo;
      5: return hi;
      6: return hi + 1;
      7: return 255;
      8: return 256;
      default: return 32767;
    endcase
  endfunction

  // Mostly a small hot window so draws stack up on the same pixels.
  task automatic push_random(input int bx, input int by);
    int          sel, x, y;
    logic [15:0] r16;
    opcode_t     op;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      x = bx + $urandom_range(0, 7);
      y = by + $urandom_range(0, 7);
    end else if (sel < 85) begin
      x = $urandom_range(0, 255);
      y = $urandom_range(0, 255);
    end else if (sel < 95) begin
      x = pick_edge(clip_lo_x, clip_hi_x);
      y = pick_edge(clip_lo_y, clip_hi_y);
    end else begin
      r16 = 16'($urandom);
      x   = $signed(r16);
      r16 = 16'($urandom);
      y   = $signed(r16);
    end
    sel = $urandom_range(0, 99);
    if (sel < 55)      op = OP_DRAW;
    else if (sel < 70) op = OP_WRITE;
    else if (sel < 95) op = OP_READ;
    else               op = OP_NOP;
    push_item(op, x, y, $urandom, $urandom_range(0, 7) == 0);
  endtask

  task automatic random_phase(input int idx);
    int lx, ly, hx, hy, bx, by, n;
    lx = $urandom_range(0, 200);
    ly = $urandom_range(0, 200);
    hx = lx + $urandom_range(0, 55);
    hy = ly + $urandom_range(0, 55);
    case (idx)
      0:  apply_settings(0, 0, 255, 255, MODE_NONE, $urandom);
      1:  apply_settings(0, 0, 255, 255, MODE_BLEND, $urandom);
      2:  apply_settings(lx, ly, hx, hy, MODE_ADD, $urandom);
      3:  apply_settings(lx, ly, hx, hy, MODE_MOD, $urandom);
      4:  apply_settings(lx, ly, hx, hy, MODE_KEEP, $urandom);
      5:  apply_settings(lx, ly, hx, hy, 3'd7, $urandom);            // unused mode code
      6:  apply_settings(hx, hy, lx, ly - 1, MODE_BLEND, $urandom);   // min above max
      7:  apply_settings(255, 255, 255, 255, MODE_ADD, 32'hFFFF_FFFF);
      8:  apply_settings(lx, ly, hx, hy, MODE_BLEND, {8'h00, 24'($urandom)});
      9:  apply_settings(0, 0, 255, 255, MODE_BLEND, {8'hFF, 24'($urandom)});
      10: apply_settings(0, 0, 255, 255, MODE_MOD, 32'h0000_0000);
      default: apply_settings(lx, ly, hx, hy, 3'($urandom_range(0, 4)), $urandom);
    endcase
    // hot window inside the clip rectangle when there is one
    if (clip_lo_x <= clip_hi_x && clip_lo_y <= clip_hi_y) begin
      bx = $urandom_range(clip_lo_x, clip_hi_x);
      by = $urandom_range(clip_lo_y, clip_hi_y);
    end else begin
      bx = $urandom_range(0, 255);
      by = $urandom_range(0, 255);
    end
    steady = (idx == 2 || idx == 3); // long stretch with no idling
    for (n = 0; n < PHASE_ITEMS; n++) begin
      // sender holds off once until every result is back
      if (idx == 4 && n == PHASE_ITEMS / 2)
        drain();
      push_random(bx, by);
    end
  endtask

  initial begin
    int p;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: raw writes and reads at the frame corners and outside it,
    // the unused opcode, and a draw with the reset settings.
    push_item(OP_WRITE, 0, 0, 32'hFFFF_FFFF, 1'b1);
    push_item(OP_WRITE, 255, 255, 32'h0000_0000, 1'b0);
    push_item(OP_WRITE, 128, 64, 32'hA5C3_5A3C, 1'b0);
    push_item(OP_READ, 0, 0, '0, 1'b0);
    push_item(OP_READ, 255, 255, '0, 1'b1);
    push_item(OP_READ, -1, 0, '0, 1'b0);
    push_item(OP_READ, 0, 256, '0, 1'b0);
    push_item(OP_WRITE, 256, 0, 32'h1234_5678, 1'b0);
    push_item(OP_WRITE, -32768, 32767, 32'hFFFF_FFFF, 1'b1);
    push_item(OP_NOP, 3, 3, 32'hFFFF_FFFF, 1'b1);
    push_item(OP_DRAW, 0, 0, '0, 1'b0);
    push_item(OP_DRAW, 128, 64, '0, 1'b1);

    // Blend inside a small rectangle, points on and just past each edge.
    apply_settings(10, 10, 20, 20, MODE_BLEND, 32'h80FF_4020);
    push_item(OP_WRITE, 10, 10, 32'h8080_8080, 1'b0);
    push_item(OP_DRAW, 10, 10, '0, 1'b0);
    push_item(OP_DRAW, 20, 20, '0, 1'b0);
    push_item(OP_DRAW, 9, 10, '0, 1'b0);
    push_item(OP_DRAW, 21, 15, '0, 1'b0);
    push_item(OP_DRAW, 10, 21, '0, 1'b0);
    push_item(OP_DRAW, 15, 9, '0, 1'b1);

    // Add with full colour saturates; modulate; keep leaves the pixel.
    apply_settings(0, 0, 255, 255, MODE_ADD, 32'hFFFF_FFFF);
    push_item(OP_DRAW, 10, 10, '0, 1'b1);
    apply_settings(0, 0, 255, 255, MODE_MOD, 32'h80FF_00FF);
    push_item(OP_DRAW, 20, 20, '0, 1'b1);
    apply_settings(0, 0, 255, 255, MODE_KEEP, 32'h1234_5678);
    push_item(OP_DRAW, 0, 0, '0, 1'b1);

    // Empty rectangle clips everything.
    apply_settings(20, 20, 10, 10, MODE_NONE, 32'h1234_5678);
    push_item(OP_DRAW, 15, 15, '0, 1'b0);
    push_item(OP_DRAW, 10, 10, '0, 1'b1);

    for (p = 0; p < PHASES; p++)
      random_phase(p);

    drain();
    steady = 1'b0;
    repeat (20) @(posedge clk);

    $display("%0d beats driven under %0d register settings, %0d results checked",
             issued, settings, received);
    $display("%0d draws landed inside the clip rectangle", draws_landed);
    if (err_count == 0 && pending_outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/cpbe_pkg.sv
rtl/cpbe_frame_mem.sv
rtl/cpbe_blend_unit.sv
rtl/clipped_point_blend_engine.sv
verif/tb.sv
